// File: rtl/spd_pkg.sv
// shared types and constants for the syn scan pair detector
`timescale 1ns / 1ps
package spd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W        = IDX_W + 1;
  localparam int ADDR_W        = 32;
  localparam int OUT_CNT_W     = 16;
  localparam int RATIO_W       = 8;
  localparam int MINREQ_W      = 16;
  localparam int PROD_W        = RATIO_W + COUNT_BITS;
  localparam int CMP_W         = (PROD_W > MINREQ_W) ? PROD_W : MINREQ_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_IGN  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // register indexes
  localparam logic [1:0] REG_RATIO   = 2'd0;
  localparam logic [1:0] REG_MIN_REQ = 2'd1;

  // one table entry as it travels round the ring
  typedef struct packed {
    logic [ADDR_W-1:0]     init;
    logic [ADDR_W-1:0]     targ;
    logic [COUNT_BITS-1:0] req;
    logic [COUNT_BITS-1:0] rep;
  } entry_t;

  // head unit decision for the current step
  typedef struct packed {
    logic ins;
    logic cap;
  } head_flags_t;

endpackage

// File: rtl/spd_cell.sv
// one table cell of the rotating entry ring
`timescale 1ns / 1ps
module spd_cell
  import spd_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  entry_t din,
  output entry_t dout
);

  entry_t data_r;

  // take the neighbor's entry on every rotation step
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= din;
    end
  end

  assign dout = data_r;

endmodule

// File: rtl/spd_head.sv
// head unit: key match, insert, count update and read capture on the entry at the ring head
`timescale 1ns / 1ps
module spd_head
  import spd_pkg::*;
(
  input  entry_t            head,
  input  logic [IDX_W-1:0]  step,
  input  logic [FILL_W-1:0] fill,
  input  logic [ADDR_W-1:0] key_a,
  input  logic [ADDR_W-1:0] key_b,
  input  logic              is_pkt,
  input  logic              is_req,
  input  logic              found,
  input  logic              rd_ok,
  input  logic [IDX_W-1:0]  rd_idx,
  output head_flags_t       flags,
  output entry_t            wb
);

  logic   used;
  logic   match;
  logic   ins;
  entry_t base;
  entry_t upd;

  always_comb begin
    used  = ({1'b0, step} < fill);
    match = is_pkt && used && (head.init == key_a) && (head.targ == key_b);
    // first free slot comes right after the used ones
    ins   = is_pkt && !found && ({1'b0, step} == fill);

    base = head;
    if (ins) begin
      base.init = key_a;
      base.targ = key_b;
      base.req  = '0;
      base.rep  = '0;
    end

    // saturating count update
    upd = base;
    if (is_req) begin
      if (base.req != COUNT_MAX) upd.req = base.req + 1'b1;
    end else begin
      if (base.rep != COUNT_MAX) upd.rep = base.rep + 1'b1;
    end

    flags.ins = ins;
    flags.cap = match || ins || (!is_pkt && rd_ok && used && (step == rd_idx));
    wb        = (match || ins) ? upd : head;
  end

endmodule

// File: rtl/syn_scan_pair_detector_unit.sv
// top level of the syn scan pair detector
`timescale 1ns / 1ps
// Tracks (initiator, target) address pairs with saturating SYN request and
// SYN-ACK reply counts, and reports one result word per input word.
// Input channel in_*: a packet word (action 0) counts a SYN under
// (src, dst) or a SYN-ACK under (dst, src); a read word (action 1) returns
// table entry entry_index with its counts and the scanner flag.
// Output channel out_*: exactly one result word per input word, in order.
// Config channel cfg_*: index 0 reply ratio, index 1 request minimum; always ready.
// The table is a ring of TABLE_ENTRIES cells rotated one place per cycle past
// a single compare/update head, so a packet or read word passes the whole
// ring in the scan state and then the evaluate state before its result is
// registered, and a non-SYN packet goes straight to evaluate; the next word
// is taken once the unit is back in idle. One word is in flight at a time;
// a new word is accepted while the previous result still waits in the output
// register. If out_stall holds the finished result, the next word waits at
// its final step until the output register frees up.
// Reset empties the table (fill count to zero) and restores the register
// defaults (ratio 3, request minimum 2); no clearing pass is needed.
module syn_scan_pair_detector_unit
  import spd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [ADDR_W-1:0]    in_src_addr,
  input  logic [ADDR_W-1:0]    in_dst_addr,
  input  logic                 in_syn_flag,
  input  logic                 in_ack_flag,
  input  logic [5:0]           in_entry_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_entry_valid,
  output logic [ADDR_W-1:0]    out_initiator_addr,
  output logic [ADDR_W-1:0]    out_target_addr,
  output logic [OUT_CNT_W-1:0] out_request_count,
  output logic [OUT_CNT_W-1:0] out_response_count,
  output logic                 out_is_scanner,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EVAL} state_t;
  typedef enum logic [1:0] {OP_PKT, OP_READ, OP_IGN} op_t;

  state_t            state_r;
  op_t               op_r;
  logic [ADDR_W-1:0] key_a_r;
  logic [ADDR_W-1:0] key_b_r;
  logic              is_req_r;
  logic              rd_ok_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [IDX_W-1:0]  step_r;
  logic [FILL_W-1:0] fill_r;
  logic              cap_v_r;
  entry_t            cap_r;
  logic [RATIO_W-1:0]  ratio_r;
  logic [MINREQ_W-1:0] minreq_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic                 out_entry_valid_r;
  logic [ADDR_W-1:0]    out_init_r;
  logic [ADDR_W-1:0]    out_targ_r;
  logic [OUT_CNT_W-1:0] out_req_r;
  logic [OUT_CNT_W-1:0] out_rep_r;
  logic                 out_scan_r;

  entry_t      cell_q [TABLE_ENTRIES];
  entry_t      wb;
  head_flags_t hflags;
  logic        shift_en;
  logic        in_acc;
  logic        rd_in_range;
  logic        last_step;
  logic        out_free;
  logic [PROD_W-1:0] prod;
  logic              scan_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign shift_en  = (state_r == S_SCAN);
  assign last_step = (step_r == IDX_W'(TABLE_ENTRIES - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign rd_in_range = ({26'd0, in_entry_index} < 32'(TABLE_ENTRIES));

  // ring of cells: each takes its upper neighbor, the top takes the head write-back
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t cin;
    if (i == TABLE_ENTRIES - 1) begin : g_top
      assign cin = wb;
    end else begin : g_mid
      assign cin = cell_q[i+1];
    end
    spd_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (cin),
      .dout     (cell_q[i])
    );
  end

  // compare and update at the ring head
  spd_head u_head (
    .head   (cell_q[0]),
    .step   (step_r),
    .fill   (fill_r),
    .key_a  (key_a_r),
    .key_b  (key_b_r),
    .is_pkt (op_r == OP_PKT),
    .is_req (is_req_r),
    .found  (cap_v_r),
    .rd_ok  (rd_ok_r),
    .rd_idx (rd_idx_r),
    .flags  (hflags),
    .wb     (wb)
  );

  // scanner test on the captured entry
  always_comb begin
    prod     = PROD_W'(ratio_r) * PROD_W'(cap_r.rep);
    scan_hit = (CMP_W'(cap_r.req) >= CMP_W'(minreq_r)) &&
               (CMP_W'(prod) < CMP_W'(cap_r.req));
  end

  // control, table fill count, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_IGN;
      step_r      <= '0;
      fill_r      <= '0;
      cap_v_r     <= 1'b0;
      ratio_r     <= RATIO_W'(3);
      minreq_r    <= MINREQ_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RATIO)   ratio_r  <= cfg_wdata[RATIO_W-1:0];
        if (cfg_index == REG_MIN_REQ) minreq_r <= cfg_wdata[MINREQ_W-1:0];
      end

      // output word handshake
      if (state_r == S_EVAL && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            step_r   <= '0;
            cap_v_r  <= 1'b0;
            is_req_r <= !in_ack_flag;
            key_a_r  <= in_ack_flag ? in_dst_addr : in_src_addr;
            key_b_r  <= in_ack_flag ? in_src_addr : in_dst_addr;
            rd_ok_r  <= rd_in_range;
            rd_idx_r <= IDX_W'(in_entry_index);
            if (in_action) begin
              op_r    <= OP_READ;
              state_r <= S_SCAN;
            end else if (in_syn_flag) begin
              op_r    <= OP_PKT;
              state_r <= S_SCAN;
            end else begin
              op_r    <= OP_IGN;
              state_r <= S_EVAL;
            end
          end
        end
        S_SCAN: begin
          if (hflags.cap) begin
            cap_v_r <= 1'b1;
            cap_r   <= wb;
          end
          if (hflags.ins) fill_r <= fill_r + 1'b1;
          step_r <= step_r + 1'b1;
          if (last_step) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (out_free) begin
            out_entry_valid_r <= 1'b0;
            out_init_r        <= '0;
            out_targ_r        <= '0;
            out_req_r         <= '0;
            out_rep_r         <= '0;
            out_scan_r        <= 1'b0;
            if (op_r == OP_IGN) begin
              out_status_r <= ST_IGN;
            end else if (op_r == OP_PKT && !cap_v_r) begin
              out_status_r <= ST_FULL;
            end else begin
              out_status_r <= ST_OK;
              if (cap_v_r) begin
                out_entry_valid_r <= 1'b1;
                out_init_r        <= cap_r.init;
                out_targ_r        <= cap_r.targ;
                out_req_r         <= OUT_CNT_W'(cap_r.req);
                out_rep_r         <= OUT_CNT_W'(cap_r.rep);
                out_scan_r        <= scan_hit;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_valid    = out_entry_valid_r;
  assign out_initiator_addr = out_init_r;
  assign out_target_addr    = out_targ_r;
  assign out_request_count  = out_req_r;
  assign out_response_count = out_rep_r;
  assign out_is_scanner     = out_scan_r;

endmodule
